[src/fhl_pkg.sv]
// ----------------------------------------------------------------------------
// fhl_pkg: shared types and constants for the folding hash insert block
// Table geometry, request and queue entry types, status and state codes.
// ----------------------------------------------------------------------------
package fhl_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned VmWordsN   = 4;
  localparam int unsigned CfgIdxW    = $clog2(VmWordsN);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned StatusW    = 2;

  typedef logic [KeyW-1:0]                key_t;
  typedef logic [AddrW-1:0]               slot_t;
  typedef logic [VmWordsN-1:0][KeyW-1:0]  vm_set_t;

  // One request waiting between the hash front and the probe back
  typedef struct packed {
    key_t  key;
    slot_t home;
  } req_t;

  typedef enum logic [StatusW-1:0] {
    StHome   = 2'd0,
    StProbed = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkCheck
  } back_state_e;

endpackage

[src/fhl_ram.sv]
// ----------------------------------------------------------------------------
// fhl_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fhl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write when enabled; read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/fhl_queue.sv]
// ----------------------------------------------------------------------------
// fhl_queue: short request queue between hash front and probe back
// Small FIFO of hashed requests so both sides stall independently.
// ----------------------------------------------------------------------------
module fhl_queue
  import fhl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  input  logic pop_i,
  output req_t head_o,
  output logic full_o,
  output logic empty_o
);

  req_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QPtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

[src/fhl_front.sv]
// ----------------------------------------------------------------------------
// fhl_front: request intake and folding hash
// Folds the key with the VM words into a home slot and queues the request.
// ----------------------------------------------------------------------------
module fhl_front
  import fhl_pkg::*;
(
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  key_t    customer_key_i,
  input  vm_set_t vm_words_i,
  input  logic    q_full_i,
  output logic    q_push_o,
  output req_t    q_req_o
);

  slot_t home;

  // Fold: only the low slot bits of the 32-bit sum matter
  always_comb begin
    home = customer_key_i[AddrW-1:0];
    for (int unsigned k = 0; k < VmWordsN; k++) begin
      home = home + vm_words_i[k][AddrW-1:0];
    end
  end

  // Accept when the queue has room
  assign in_stall_o   = q_full_i;
  assign q_push_o     = in_valid_i && !q_full_i;
  assign q_req_o.key  = customer_key_i;
  assign q_req_o.home = home;

endmodule

[src/fhl_back.sv]
// ----------------------------------------------------------------------------
// fhl_back: linear probe sequencer and slot store
// Walks slots from home, fills the first empty one, links it from home when it
// lies past home, and drives the registered result, full if no slot was empty.
// ----------------------------------------------------------------------------
module fhl_back
  import fhl_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vm_set_t       vm_words_i,
  input  logic          q_empty_i,
  input  req_t          q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output slot_t         home_slot_o,
  output slot_t         placed_slot_o,
  output logic [StatusW-1:0] insert_status_o
);

  back_state_e state_q, state_d;

  key_t    key_q;
  slot_t   home_q;
  slot_t   cur_q;
  slot_t   step_q;
  logic [TableDepth-1:0] slot_vld_q;

  logic    out_vld_q;
  slot_t   out_home_q;
  slot_t   out_placed_q;
  status_e out_status_q;

  key_t    rd_key;
  logic    slot_empty;
  logic    last_probe;
  logic    out_free;
  logic    finish;
  logic    store;
  logic    advance;
  logic    link_wr;

  // Slot storage: keys, VM words, links
  fhl_ram #(.Width(KeyW), .Depth(TableDepth)) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (store),
    .wr_addr_i (cur_q),
    .wr_data_i (key_q),
    .rd_addr_i (cur_q),
    .rd_data_o (rd_key)
  );

  fhl_ram #(.Width(KeyW*VmWordsN), .Depth(TableDepth)) u_vm_ram (
    .clk_i     (clk_i),
    .wr_en_i   (store),
    .wr_addr_i (cur_q),
    .wr_data_i (vm_words_i),
    .rd_addr_i (cur_q),
    .rd_data_o ()
  );

  fhl_ram #(.Width(AddrW), .Depth(TableDepth)) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (link_wr),
    .wr_addr_i (home_q),
    .wr_data_i (cur_q),
    .rd_addr_i (home_q),
    .rd_data_o ()
  );

  // Probe decision
  assign slot_empty = !slot_vld_q[cur_q] || (rd_key == '0);
  assign last_probe = (step_q == AddrW'(TableDepth - 1));
  assign out_free   = !out_vld_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          state_d = BkRead;
        end
      end
      BkRead: begin
        state_d = BkCheck;
      end
      BkCheck: begin
        if (finish) begin
          state_d = BkIdle;
        end else if (advance) begin
          state_d = BkRead;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o = 1'b0;
    finish  = 1'b0;
    advance = 1'b0;
    unique case (state_q)
      BkIdle: begin
        q_pop_o = !q_empty_i;
      end
      BkRead: begin
        q_pop_o = 1'b0;
      end
      BkCheck: begin
        finish  = out_free && (slot_empty || last_probe);
        advance = !slot_empty && !last_probe;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  assign store   = finish && slot_empty;
  assign link_wr = store && (step_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BkIdle;
      slot_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (store) begin
        slot_vld_q[cur_q] <= 1'b1;
      end
      // Load result or drop it once taken
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request and probe position
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      key_q  <= q_head_i.key;
      home_q <= q_head_i.home;
      cur_q  <= q_head_i.home;
      step_q <= '0;
    end else if (advance) begin
      cur_q  <= cur_q + 1'b1;
      step_q <= step_q + 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_home_q <= home_q;
      if (!slot_empty) begin
        out_placed_q <= home_q;
        out_status_q <= StFull;
      end else if (step_q == '0) begin
        out_placed_q <= cur_q;
        out_status_q <= StHome;
      end else begin
        out_placed_q <= cur_q;
        out_status_q <= StProbed;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign home_slot_o     = out_home_q;
  assign placed_slot_o   = out_placed_q;
  assign insert_status_o = out_status_q;

endmodule

[src/folding_hash_linear_probe_insert.sv]
// ----------------------------------------------------------------------------
// folding_hash_linear_probe_insert: hash insert with linear probing
// Flow: hash and queue the key, read each probed slot in turn, then register the result.
// The queue takes new keys while the back probes one key at a time, until it is full.
// Reset clears VM words, slot valid flags and the queue; the table reads empty.
// ----------------------------------------------------------------------------
module folding_hash_linear_probe_insert
  import fhl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [KeyW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KeyW-1:0]    customer_key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [AddrW-1:0]   home_slot_o,
  output logic [AddrW-1:0]   placed_slot_o,
  output logic [StatusW-1:0] insert_status_o
);

  vm_set_t vm_words_q;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  req_t    q_push_req;
  req_t    q_head;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_words_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vm_words_q[cfg_index_i] <= cfg_data_i;
    end
  end

  fhl_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .customer_key_i (customer_key_i),
    .vm_words_i     (vm_words_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_req_o        (q_push_req)
  );

  fhl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_req_i (q_push_req),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  fhl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vm_words_i      (vm_words_q),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .home_slot_o     (home_slot_o),
    .placed_slot_o   (placed_slot_o),
    .insert_status_o (insert_status_o)
  );

endmodule
